### rtl/clp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_pkg
// Shared widths, constants and pipeline payload types for the closest
// points between two lines block.
// ----------------------------------------------------------------------------
package clp_pkg;

  localparam int QW        = 24;          // Q12.12 field width
  localparam int CFG_W     = 32;
  localparam int FRAC_W    = 24;          // threshold scale, 2^-24 units
  localparam logic [CFG_W-1:0] THR_RESET = 32'd17;
  localparam int Q_MAX     = 8388607;
  localparam int Q_MIN     = -8388608;
  localparam int PP_W      = 49;          // 24 x 25 bit product
  localparam int DOT_W     = 52;          // dot product sums
  localparam int HALF_W    = DOT_W / 2;   // multiplier split
  localparam int PROD_W    = 2 * DOT_W;   // wide products, det, numerators
  localparam int NUM_SHIFT = 13;          // numerator pre-scale for rounding
  localparam int QDIV_W    = 26;          // quotient bits kept by the divider
  localparam int DIV_STEPS = QDIV_W;
  localparam int PM_W      = 2 * QW;      // parameter x direction product
  localparam int SQ_W      = 49;          // one squared difference
  localparam int S_W       = 52;          // sum of squares, root working width
  localparam int SQ_STEPS  = S_W / 2;
  localparam int GAP_W     = 25;

  typedef logic signed [QW-1:0] q_t;
  typedef q_t [2:0] vec3_t;

  typedef struct packed {
    vec3_t pa;
    vec3_t da;
    vec3_t pb;
    vec3_t db;
  } lines_t;

  typedef struct packed {
    lines_t ln;
    logic   par;
    logic   neg_a;
    logic   neg_b;
    logic   ovf_a;
    logic   ovf_b;
  } side_t;

  typedef struct packed {
    logic [PROD_W-1:0] rem_a;
    logic [PROD_W-1:0] rem_b;
    logic [PROD_W-1:0] un_a;
    logic [PROD_W-1:0] un_b;
    logic [PROD_W-1:0] ud;
    logic [QDIV_W-1:0] q_a;
    logic [QDIV_W-1:0] q_b;
    side_t             side;
  } div_st_t;

  typedef struct packed {
    logic  par;
    q_t    ta;
    q_t    tb;
    vec3_t na;
    vec3_t nb;
  } res_t;

  typedef struct packed {
    logic [S_W-1:0] s;
    logic [S_W-1:0] r;
    res_t           res;
  } sq_st_t;

endpackage

### rtl/clp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_mul
// Two-stage signed 52 x 52 multiplier built from four 26-bit partial
// products, summed in the second stage.
// ----------------------------------------------------------------------------
module clp_mul import clp_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DOT_W-1:0]  a,
  input  logic signed [DOT_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  logic [HALF_W-1:0]            a_lo, b_lo;
  logic signed [HALF_W-1:0]     a_hi, b_hi;
  logic [2*HALF_W-1:0]          ll_r;
  logic signed [2*HALF_W:0]     lh_r, hl_r;
  logic signed [2*HALF_W-1:0]   hh_r;
  logic signed [PROD_W-1:0]     p_r;

  assign a_lo = a[HALF_W-1:0];
  assign b_lo = b[HALF_W-1:0];
  assign a_hi = a[DOT_W-1:HALF_W];
  assign b_hi = b[DOT_W-1:HALF_W];

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a_lo * b_lo;
      lh_r <= $signed({1'b0, a_lo}) * b_hi;
      hl_r <= a_hi * $signed({1'b0, b_lo});
      hh_r <= a_hi * b_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (PROD_W'(hh_r) << (2*HALF_W))
           + ((PROD_W'(lh_r) + PROD_W'(hl_r)) << HALF_W)
           + PROD_W'(ll_r);
    end
  end

  assign p = p_r;

endmodule

### rtl/clp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_div
// Pipelined restoring divider, one quotient bit per stage, two dividends
// over a shared divisor, with the line payload carried alongside.
// ----------------------------------------------------------------------------
module clp_div import clp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_v,
  input  div_st_t in_st,
  output logic    out_v,
  output div_st_t out_st
);

  div_st_t st_r [DIV_STEPS];
  logic    v_r  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int QB = QDIV_W - 1 - k;
    div_st_t           src, st_nxt;
    logic              src_v;
    logic              bit_a, bit_b;
    logic [PROD_W-1:0] ra, rb;

    if (k == 0) begin : g_first
      assign src   = in_st;
      assign src_v = in_v;
    end else begin : g_rest
      assign src   = st_r[k-1];
      assign src_v = v_r[k-1];
    end

    // low numerator bits are the zero padding of the pre-scale
    if (QB >= NUM_SHIFT) begin : g_num
      assign bit_a = src.un_a[QB-NUM_SHIFT];
      assign bit_b = src.un_b[QB-NUM_SHIFT];
    end else begin : g_pad
      assign bit_a = 1'b0;
      assign bit_b = 1'b0;
    end

    assign ra = {src.rem_a[PROD_W-2:0], bit_a};
    assign rb = {src.rem_b[PROD_W-2:0], bit_b};

    always_comb begin
      st_nxt       = src;
      st_nxt.rem_a = ra;
      st_nxt.rem_b = rb;
      if (ra >= src.ud) begin
        st_nxt.rem_a  = ra - src.ud;
        st_nxt.q_a[QB] = 1'b1;
      end
      if (rb >= src.ud) begin
        st_nxt.rem_b  = rb - src.ud;
        st_nxt.q_b[QB] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign out_v  = v_r[DIV_STEPS-1];
  assign out_st = st_r[DIV_STEPS-1];

endmodule

### rtl/clp_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_sqrt
// Pipelined digit-by-digit integer square root, one result bit per stage,
// leaving root and remainder for the final rounding.
// ----------------------------------------------------------------------------
module clp_sqrt import clp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_v,
  input  sq_st_t in_st,
  output logic   out_v,
  output sq_st_t out_st
);

  sq_st_t st_r [SQ_STEPS];
  logic   v_r  [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [S_W-1:0] BIT = S_W'(1) << (2 * (SQ_STEPS - 1 - k));
    sq_st_t         src, st_nxt;
    logic           src_v;
    logic [S_W-1:0] trial;

    if (k == 0) begin : g_first
      assign src   = in_st;
      assign src_v = in_v;
    end else begin : g_rest
      assign src   = st_r[k-1];
      assign src_v = v_r[k-1];
    end

    assign trial = src.r + BIT;

    always_comb begin
      st_nxt = src;
      if (src.s >= trial) begin
        st_nxt.s = src.s - trial;
        st_nxt.r = (src.r >> 1) + BIT;
      end else begin
        st_nxt.r = src.r >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign out_v  = v_r[SQ_STEPS-1];
  assign out_st = st_r[SQ_STEPS-1];

endmodule

### rtl/closest_points_between_lines.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_points_between_lines
// Closest points of two 3D lines in Q12.12: dot products, determinant,
// line parameters by pipelined division, closest points and their distance
// by pipelined square root.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    two lines, point and direction
//   out_     output     out_valid / out_ready  found, params, points, gap
//   cfg_     input      cfg_valid / cfg_ready  parallel threshold (32 bits)
//
// One transaction per cycle while the output is not stalled; the pipeline holds the 26
// divider stages and the 26 square root stages plus 13 arithmetic stages.
// Reset clears all valid bits and loads the threshold with 17.
// A stalled output freezes the whole pipeline in place; in_ready follows it.
// ----------------------------------------------------------------------------
module closest_points_between_lines import clp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [QW-1:0]    in_point_a_x,
  input  logic [QW-1:0]    in_point_a_y,
  input  logic [QW-1:0]    in_point_a_z,
  input  logic [QW-1:0]    in_dir_a_x,
  input  logic [QW-1:0]    in_dir_a_y,
  input  logic [QW-1:0]    in_dir_a_z,
  input  logic [QW-1:0]    in_point_b_x,
  input  logic [QW-1:0]    in_point_b_y,
  input  logic [QW-1:0]    in_point_b_z,
  input  logic [QW-1:0]    in_dir_b_x,
  input  logic [QW-1:0]    in_dir_b_y,
  input  logic [QW-1:0]    in_dir_b_z,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_found,
  output logic [QW-1:0]    out_param_a,
  output logic [QW-1:0]    out_param_b,
  output logic [QW-1:0]    out_near_a_x,
  output logic [QW-1:0]    out_near_a_y,
  output logic [QW-1:0]    out_near_a_z,
  output logic [QW-1:0]    out_near_b_x,
  output logic [QW-1:0]    out_near_b_y,
  output logic [QW-1:0]    out_near_b_z,
  output logic [GAP_W-1:0] out_gap,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  function automatic q_t to_param(logic [QDIV_W-1:0] q, logic neg, logic ovf);
    logic [QDIV_W-1:0] h;
    logic [QDIV_W-1:0] lim;
    h   = QDIV_W'(({1'b0, q} + 1'b1) >> 1);
    lim = neg ? QDIV_W'(-Q_MIN) : QDIV_W'(Q_MAX);
    if (ovf || h > lim) begin
      h = lim;
    end
    return neg ? QW'(QDIV_W'(0) - h) : QW'(h);
  endfunction

  function automatic q_t sat_q(logic signed [PM_W:0] v);
    q_t res;
    if (v > Q_MAX) begin
      res = QW'(Q_MAX);
    end else if (v < Q_MIN) begin
      res = QW'(Q_MIN);
    end else begin
      res = QW'(v);
    end
    return res;
  endfunction

  logic en;
  logic [CFG_W-1:0] thr_r;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // ---------------- input register
  logic   v0_r;
  lines_t ln0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln0_r.pa <= {in_point_a_z, in_point_a_y, in_point_a_x};
      ln0_r.da <= {in_dir_a_z, in_dir_a_y, in_dir_a_x};
      ln0_r.pb <= {in_point_b_z, in_point_b_y, in_point_b_x};
      ln0_r.db <= {in_dir_b_z, in_dir_b_y, in_dir_b_x};
    end
  end

  // ---------------- per-component products
  logic                   v1_r;
  lines_t                 ln1_r;
  logic signed [PP_W-1:0] paa_r [3];
  logic signed [PP_W-1:0] pab_r [3];
  logic signed [PP_W-1:0] pbb_r [3];
  logic signed [PP_W-1:0] pad_r [3];
  logic signed [PP_W-1:0] pbd_r [3];
  logic signed [QW:0]     w0 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w0[i] = $signed(ln0_r.pa[i]) - $signed(ln0_r.pb[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln1_r <= ln0_r;
      for (int i = 0; i < 3; i++) begin
        paa_r[i] <= $signed(ln0_r.da[i]) * $signed(ln0_r.da[i]);
        pab_r[i] <= $signed(ln0_r.da[i]) * $signed(ln0_r.db[i]);
        pbb_r[i] <= $signed(ln0_r.db[i]) * $signed(ln0_r.db[i]);
        pad_r[i] <= $signed(ln0_r.da[i]) * w0[i];
        pbd_r[i] <= $signed(ln0_r.db[i]) * w0[i];
      end
    end
  end

  // ---------------- dot products
  logic                    v2_r;
  lines_t                  ln2_r;
  logic signed [DOT_W-1:0] aa_r, ab_r, bb_r, ad_r, bd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln2_r <= ln1_r;
      aa_r  <= DOT_W'(paa_r[0]) + DOT_W'(paa_r[1]) + DOT_W'(paa_r[2]);
      ab_r  <= DOT_W'(pab_r[0]) + DOT_W'(pab_r[1]) + DOT_W'(pab_r[2]);
      bb_r  <= DOT_W'(pbb_r[0]) + DOT_W'(pbb_r[1]) + DOT_W'(pbb_r[2]);
      ad_r  <= DOT_W'(pad_r[0]) + DOT_W'(pad_r[1]) + DOT_W'(pad_r[2]);
      bd_r  <= DOT_W'(pbd_r[0]) + DOT_W'(pbd_r[1]) + DOT_W'(pbd_r[2]);
    end
  end

  // ---------------- wide products, two stages
  logic                     v3_r, v4_r;
  lines_t                   ln3_r, ln4_r;
  logic signed [PROD_W-1:0] p_aabb, p_abab, p_abbd, p_bbad, p_aabd, p_abad;

  clp_mul u_mul_aabb (.clk(clk), .en(en), .a(aa_r), .b(bb_r), .p(p_aabb));
  clp_mul u_mul_abab (.clk(clk), .en(en), .a(ab_r), .b(ab_r), .p(p_abab));
  clp_mul u_mul_abbd (.clk(clk), .en(en), .a(ab_r), .b(bd_r), .p(p_abbd));
  clp_mul u_mul_bbad (.clk(clk), .en(en), .a(bb_r), .b(ad_r), .p(p_bbad));
  clp_mul u_mul_aabd (.clk(clk), .en(en), .a(aa_r), .b(bd_r), .p(p_aabd));
  clp_mul u_mul_abad (.clk(clk), .en(en), .a(ab_r), .b(ad_r), .p(p_abad));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln3_r <= ln2_r;
      ln4_r <= ln3_r;
    end
  end

  // ---------------- determinant and numerators
  logic                     v5_r;
  lines_t                   ln5_r;
  logic signed [PROD_W-1:0] det_r, numa_r, numb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln5_r  <= ln4_r;
      det_r  <= p_aabb - p_abab;
      numa_r <= p_abbd - p_bbad;
      numb_r <= p_aabd - p_abad;
    end
  end

  // ---------------- magnitudes, parallel test, divider set-up
  logic              v6_r;
  div_st_t           div_in_r, div_in_nxt;
  logic [PROD_W-1:0] un_a, un_b, ud;

  always_comb begin
    un_a = numa_r[PROD_W-1] ? PROD_W'(-numa_r) : PROD_W'(numa_r);
    un_b = numb_r[PROD_W-1] ? PROD_W'(-numb_r) : PROD_W'(numb_r);
    ud   = det_r[PROD_W-1]  ? PROD_W'(-det_r)  : PROD_W'(det_r);
    div_in_nxt.rem_a       = un_a >> NUM_SHIFT;
    div_in_nxt.rem_b       = un_b >> NUM_SHIFT;
    div_in_nxt.un_a        = un_a;
    div_in_nxt.un_b        = un_b;
    div_in_nxt.ud          = ud;
    div_in_nxt.q_a         = '0;
    div_in_nxt.q_b         = '0;
    div_in_nxt.side.ln     = ln5_r;
    div_in_nxt.side.par    = PROD_W'({thr_r, {FRAC_W{1'b0}}}) >= ud;
    div_in_nxt.side.neg_a  = numa_r[PROD_W-1] ^ det_r[PROD_W-1];
    div_in_nxt.side.neg_b  = numb_r[PROD_W-1] ^ det_r[PROD_W-1];
    // quotient would need more than the kept bits
    div_in_nxt.side.ovf_a  = (un_a >> NUM_SHIFT) >= ud;
    div_in_nxt.side.ovf_b  = (un_b >> NUM_SHIFT) >= ud;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_in_r <= div_in_nxt;
    end
  end

  logic    div_v;
  div_st_t div_out;

  clp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (v6_r),
    .in_st (div_in_r),
    .out_v (div_v),
    .out_st(div_out)
  );

  // ---------------- round and saturate parameters
  logic   v7_r;
  lines_t ln7_r;
  logic   par7_r;
  q_t     ta7_r, tb7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln7_r  <= div_out.side.ln;
      par7_r <= div_out.side.par;
      ta7_r  <= to_param(div_out.q_a, div_out.side.neg_a, div_out.side.ovf_a);
      tb7_r  <= to_param(div_out.q_b, div_out.side.neg_b, div_out.side.ovf_b);
    end
  end

  // ---------------- parameter times direction
  logic                   v8_r;
  lines_t                 ln8_r;
  logic                   par8_r;
  q_t                     ta8_r, tb8_r;
  logic signed [PM_W-1:0] pta_r [3];
  logic signed [PM_W-1:0] ptb_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln8_r  <= ln7_r;
      par8_r <= par7_r;
      ta8_r  <= ta7_r;
      tb8_r  <= tb7_r;
      for (int i = 0; i < 3; i++) begin
        pta_r[i] <= $signed(ln7_r.da[i]) * ta7_r;
        ptb_r[i] <= $signed(ln7_r.db[i]) * tb7_r;
      end
    end
  end

  // ---------------- closest points
  logic  v9_r;
  res_t  res9_r, res9_nxt;
  logic signed [PM_W:0] ex_a [3];
  logic signed [PM_W:0] ex_b [3];

  always_comb begin
    res9_nxt.par = par8_r;
    res9_nxt.ta  = ta8_r;
    res9_nxt.tb  = tb8_r;
    for (int i = 0; i < 3; i++) begin
      // round half up to Q12.12
      ex_a[i] = ((PM_W+1)'(pta_r[i]) + 2048) >>> 12;
      ex_b[i] = ((PM_W+1)'(ptb_r[i]) + 2048) >>> 12;
      res9_nxt.na[i] = sat_q(ex_a[i] + (PM_W+1)'($signed(ln8_r.pa[i])));
      res9_nxt.nb[i] = sat_q(ex_b[i] + (PM_W+1)'($signed(ln8_r.pb[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res9_r <= res9_nxt;
    end
  end

  // ---------------- squared differences
  logic                   v10_r;
  res_t                   res10_r;
  logic [SQ_W-1:0]        sq_r [3];
  logic signed [QW:0]     dd [3];
  logic signed [2*QW+1:0] dsq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i]  = $signed(res9_r.na[i]) - $signed(res9_r.nb[i]);
      dsq[i] = dd[i] * dd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (en) begin
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res10_r <= res9_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= SQ_W'(dsq[i]);
      end
    end
  end

  // ---------------- sum of squares into the root
  logic   v11_r;
  sq_st_t sq_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v11_r <= 1'b0;
    end else if (en) begin
      v11_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_in_r.s   <= S_W'(sq_r[0]) + S_W'(sq_r[1]) + S_W'(sq_r[2]);
      sq_in_r.r   <= '0;
      sq_in_r.res <= res10_r;
    end
  end

  logic   sq_v;
  sq_st_t sq_out;

  clp_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (v11_r),
    .in_st (sq_in_r),
    .out_v (sq_v),
    .out_st(sq_out)
  );

  // ---------------- output register
  logic             out_valid_r;
  res_t             out_res_r;
  logic             out_found_r;
  logic [GAP_W-1:0] out_gap_r;
  logic [S_W-1:0]   root_rnd;

  assign root_rnd = (sq_out.s > sq_out.r) ? sq_out.r + 1'b1 : sq_out.r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_v;
    end
  end

  // parallel lines report all-zero fields
  always_ff @(posedge clk) begin
    if (en) begin
      if (sq_out.res.par) begin
        out_found_r <= 1'b0;
        out_res_r   <= '0;
        out_gap_r   <= '0;
      end else begin
        out_found_r <= 1'b1;
        out_res_r   <= sq_out.res;
        out_gap_r   <= GAP_W'(root_rnd);
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_param_a  = out_res_r.ta;
  assign out_param_b  = out_res_r.tb;
  assign out_near_a_x = out_res_r.na[0];
  assign out_near_a_y = out_res_r.na[1];
  assign out_near_a_z = out_res_r.na[2];
  assign out_near_b_x = out_res_r.nb[0];
  assign out_near_b_y = out_res_r.nb[1];
  assign out_near_b_z = out_res_r.nb[2];
  assign out_gap      = out_gap_r;

endmodule

### sim/closest_points_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_points_checker
// Watches the line pair, result and threshold channels of the closest points
// block, works out the expected closest points for each accepted pair and
// compares every result transaction with the oldest one still due.
// ----------------------------------------------------------------------------
module closest_points_checker import clp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [QW-1:0]    in_point_a_x,
  input  logic [QW-1:0]    in_point_a_y,
  input  logic [QW-1:0]    in_point_a_z,
  input  logic [QW-1:0]    in_dir_a_x,
  input  logic [QW-1:0]    in_dir_a_y,
  input  logic [QW-1:0]    in_dir_a_z,
  input  logic [QW-1:0]    in_point_b_x,
  input  logic [QW-1:0]    in_point_b_y,
  input  logic [QW-1:0]    in_point_b_z,
  input  logic [QW-1:0]    in_dir_b_x,
  input  logic [QW-1:0]    in_dir_b_y,
  input  logic [QW-1:0]    in_dir_b_z,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             out_found,
  input  logic [QW-1:0]    out_param_a,
  input  logic [QW-1:0]    out_param_b,
  input  logic [QW-1:0]    out_near_a_x,
  input  logic [QW-1:0]    out_near_a_y,
  input  logic [QW-1:0]    out_near_a_z,
  input  logic [QW-1:0]    out_near_b_x,
  input  logic [QW-1:0]    out_near_b_y,
  input  logic [QW-1:0]    out_near_b_z,
  input  logic [GAP_W-1:0] out_gap,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output int               mismatch_count,
  output int               pending_results
);

  typedef logic [QW-1:0] field_t;

  // found, ta, tb, na xyz, nb xyz, gap
  typedef struct packed {
    logic          found;
    field_t        ta;
    field_t        tb;
    field_t        nax;
    field_t        nay;
    field_t        naz;
    field_t        nbx;
    field_t        nby;
    field_t        nbz;
    logic [GAP_W-1:0] gap;
  } closest_t;

  closest_t          closest_due[$];
  logic [CFG_W-1:0]  thr;

  function automatic field_t line_param(logic signed [127:0] num,
                                        logic signed [127:0] den);
    logic          neg;
    logic [127:0]  un, ud, q, lim;
    neg = num[127] ^ den[127];
    un  = num[127] ? -num : num;
    ud  = den[127] ? -den : den;
    q   = (un << NUM_SHIFT) / ud;
    q   = (q + 128'd1) >> 1;
    lim = neg ? 128'd8388608 : 128'd8388607;
    if (q > lim) q = lim;
    return neg ? field_t'(-q) : field_t'(q);
  endfunction

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic logic [63:0] root_nearest(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return (s > r) ? r + 1 : r;
  endfunction

  function automatic closest_t closest_of(field_t f[12], logic [CFG_W-1:0] t);
    longint pa[3], da[3], pb[3], db[3], na[3], nb[3], w, d, ta, tb;
    logic signed [127:0] aa, ab, bb, ad, bd, det, numa, numb;
    logic [127:0] adet, lim;
    logic [63:0] sq;
    closest_t c;
    c = '0;
    aa = 0; ab = 0; bb = 0; ad = 0; bd = 0; sq = 0;
    for (int i = 0; i < 3; i++) begin
      pa[i] = longint'($signed(f[i]));
      da[i] = longint'($signed(f[3+i]));
      pb[i] = longint'($signed(f[6+i]));
      db[i] = longint'($signed(f[9+i]));
      w  = pa[i] - pb[i];
      aa = aa + da[i] * da[i];
      ab = ab + da[i] * db[i];
      bb = bb + db[i] * db[i];
      ad = ad + da[i] * w;
      bd = bd + db[i] * w;
    end
    det  = aa * bb - ab * ab;
    adet = det[127] ? -det : det;
    lim  = 128'(t) << FRAC_W;
    if (adet <= lim) return c;
    numa = ab * bd - bb * ad;
    numb = aa * bd - ab * ad;
    ta = longint'($signed(line_param(numa, det)));
    tb = longint'($signed(line_param(numb, det)));
    for (int i = 0; i < 3; i++) begin
      na[i] = clamp_q(pa[i] + ((da[i] * ta + 2048) >>> 12));
      nb[i] = clamp_q(pb[i] + ((db[i] * tb + 2048) >>> 12));
      d  = na[i] - nb[i];
      sq = sq + 64'(d * d);
    end
    c.found = 1'b1;
    c.ta  = field_t'(ta);
    c.tb  = field_t'(tb);
    c.nax = field_t'(na[0]); c.nay = field_t'(na[1]); c.naz = field_t'(na[2]);
    c.nbx = field_t'(nb[0]); c.nby = field_t'(nb[1]); c.nbz = field_t'(nb[2]);
    c.gap = GAP_W'(root_nearest(sq));
    return c;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  assign pending_results = closest_due.size();

  initial mismatch_count = 0;

  always @(posedge clk) begin
    field_t   f[12];
    closest_t e;
    if (!rst_n) begin
      thr <= THR_RESET;
      closest_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) thr <= cfg_data;
      if (in_valid && in_ready) begin
        f = '{in_point_a_x, in_point_a_y, in_point_a_z, in_dir_a_x, in_dir_a_y,
              in_dir_a_z, in_point_b_x, in_point_b_y, in_point_b_z, in_dir_b_x,
              in_dir_b_y, in_dir_b_z};
        closest_due.push_back(closest_of(f, thr));
      end
      if (out_valid && out_ready) begin
        if (closest_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result transaction, expected none, got gap %h",
                   $time, out_gap);
        end else begin
          e = closest_due.pop_front();
          compare_field("found",    e.found, out_found);
          compare_field("param_a",  e.ta,    out_param_a);
          compare_field("param_b",  e.tb,    out_param_b);
          compare_field("near_a_x", e.nax,   out_near_a_x);
          compare_field("near_a_y", e.nay,   out_near_a_y);
          compare_field("near_a_z", e.naz,   out_near_a_z);
          compare_field("near_b_x", e.nbx,   out_near_b_x);
          compare_field("near_b_y", e.nby,   out_near_b_y);
          compare_field("near_b_z", e.nbz,   out_near_b_z);
          compare_field("gap",      e.gap,   out_gap);
        end
      end
    end
  end

endmodule

### sim/closest_points_between_lines_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_points_between_lines_test
// Drives line pairs and threshold settings into the closest points block
// with random idling on both sides and one long output stall; the checker
// beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module closest_points_between_lines_test;
  import clp_pkg::*;

  localparam int LATENCY  = 80;
  localparam int N_RANDOM = 2000;

  logic             clk, rst_n;
  logic             in_valid, in_ready;
  logic [QW-1:0]    in_point_a_x, in_point_a_y, in_point_a_z;
  logic [QW-1:0]    in_dir_a_x, in_dir_a_y, in_dir_a_z;
  logic [QW-1:0]    in_point_b_x, in_point_b_y, in_point_b_z;
  logic [QW-1:0]    in_dir_b_x, in_dir_b_y, in_dir_b_z;
  logic             out_valid, out_ready, out_found;
  logic [QW-1:0]    out_param_a, out_param_b;
  logic [QW-1:0]    out_near_a_x, out_near_a_y, out_near_a_z;
  logic [QW-1:0]    out_near_b_x, out_near_b_y, out_near_b_z;
  logic [GAP_W-1:0] out_gap;
  logic             cfg_valid, cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  int               mismatch_count, pending_results;
  logic             idle_on, hold_req;

  typedef logic [QW-1:0] field_t;

  closest_points_between_lines u_top (.*);
  closest_points_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int   n;
    logic hold_done;
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        n = 0;
        while (n < 300) begin
          @(posedge clk);
          n++;
        end
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_lines(field_t f[12]);
    in_valid     <= 1'b1;
    in_point_a_x <= f[0]; in_point_a_y <= f[1]; in_point_a_z <= f[2];
    in_dir_a_x   <= f[3]; in_dir_a_y   <= f[4]; in_dir_a_z   <= f[5];
    in_point_b_x <= f[6]; in_point_b_y <= f[7]; in_point_b_z <= f[8];
    in_dir_b_x   <= f[9]; in_dir_b_y   <= f[10]; in_dir_b_z  <= f[11];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic write_threshold(logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic field_t pick_value(int mode);
    case (mode)
      0:       return field_t'($urandom);
      1:       return field_t'($signed($urandom_range(0, 65535)) - 32768);
      2:       return field_t'($signed($urandom_range(0, 4095)) - 2048);
      default: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
    endcase
  endfunction

  function automatic void random_lines(output field_t f[12]);
    int  mode, k;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++)
      f[i] = pick_value(mode < 2 ? 0 : (mode < 5 ? 1 : (mode < 8 ? 2 :
                        $urandom_range(0, 3))));
    // near-parallel pair: second direction a multiple of the first, nudged
    if ($urandom_range(0, 7) == 0) begin
      k = $urandom_range(1, 4);
      for (int i = 0; i < 3; i++)
        f[9+i] = field_t'($signed(f[3+i]) * k + $signed($urandom_range(0, 2)) - 1);
    end
  endfunction

  initial begin
    field_t f[12];
    field_t one, mn, mx;
    logic [CFG_W-1:0] thr_set[4];
    one = 24'h001000; mn = 24'h800000; mx = 24'h7fffff;
    rst_n = 1'b0; in_valid = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
    idle_on = 1'b1; hold_req = 1'b0;
    {in_point_a_x, in_point_a_y, in_point_a_z, in_dir_a_x, in_dir_a_y, in_dir_a_z,
     in_point_b_x, in_point_b_y, in_point_b_z, in_dir_b_x, in_dir_b_y, in_dir_b_z} = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero directions, extremes, axis lines, parallel and skew pairs
    f = '{default: '0};                                            send_lines(f);
    f = '{default: mx};                                            send_lines(f);
    f = '{default: mn};                                            send_lines(f);
    f = '{mx, mn, mx, mn, mx, mn, mn, mx, mn, mx, mn, mx};         send_lines(f);
    f = '{0, 0, 0, one, 0, 0, 0, 0, one, 0, one, 0};               send_lines(f);
    f = '{0, 0, 0, one, 0, 0, 0, one, 0, one, 0, 0};               send_lines(f);
    f = '{mx, 0, 0, 0, one, 0, mn, 0, 0, 0, 0, one};               send_lines(f);
    f = '{0, 0, 0, one, 1, 0, 0, one, 0, one, 0, 0};               send_lines(f);
    f = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0};                     send_lines(f);
    f = '{0, 0, 0, 3, 0, 0, 0, 0, 5, 0, 2, 0};                     send_lines(f);
    f = '{0, 0, 0, 5, 0, 0, 0, 0, 5, 0, 5, 0};                     send_lines(f);
    f = '{mx, mx, mx, 1, 0, 0, mn, mn, mn, 0, 0, 1};               send_lines(f);
    f = '{mn, mx, 0, mx, 1, 0, mx, mn, 0, 0, mn, 1};               send_lines(f);

    thr_set = '{32'd0, 32'hffffffff, $urandom, 32'd17};
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thr_set[ph]);
      f = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 2, 0, 0};                   send_lines(f);
      f = '{0, 0, 0, 3, 0, 0, 0, 0, 5, 0, 2, 0};                   send_lines(f);
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        if (ph == 1 && n == 50) hold_req <= 1'b1;
        if (ph == 1 && n == 60) hold_req <= 1'b0;
        if (ph == 3 && n == N_RANDOM / 4 - 100) idle_on <= 1'b0;
        random_lines(f);
        send_lines(f);
      end
    end
    in_valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
